>>> hw/rtl/mrpt_pkg.sv
// package for the 64-bit miller-rabin prime test unit
// shared types, constants and tables; no dependencies
`default_nettype none
package mrpt_pkg;
  localparam int unsigned W = 64;
  localparam int unsigned NumBases = 12;
  localparam int unsigned NumRanges = 8;

  typedef logic [W-1:0] word_t;
  typedef logic [3:0] bidx_t;
  typedef logic [6:0] cnt_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_STRIP, S_BSTART, S_PSTEP, S_PMUL, S_PSQGO, S_PSQ,
    S_EVAL, S_SQ, S_SQCHK, S_DONE
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture candidate
    logic strip;     // shift d right by one, count r
    logic bstart;    // acc = 1, g = base mod n, e = d
    logic mul_go;    // start a modular multiply
    logic [1:0] mul_sel; // operands of the multiply
    logic mul_done_acc;  // write product
    logic sq_inc;    // count one squaring in the witness loop
  } cmd_t;

  localparam logic [1:0] MulAccG = 2'd0;
  localparam logic [1:0] MulGG   = 2'd1;
  localparam logic [1:0] MulXX   = 2'd2;

  typedef struct packed {
    logic small_lt2;
    logic is_two;
    logic is_even;
    logic d_odd;
    logic e_zero;
    logic e_lsb;
    logic mul_busy;
    logic x_pass;    // x == 1 or x == n-1
    logic x_nm1;
    logic sq_last;   // j reached r
    logic base_last; // last base for this candidate
  } stat_t;

  function automatic word_t base_val(input bidx_t i);
    case (i)
      4'd0: base_val = 64'd2;
      4'd1: base_val = 64'd3;
      4'd2: base_val = 64'd5;
      4'd3: base_val = 64'd7;
      4'd4: base_val = 64'd11;
      4'd5: base_val = 64'd13;
      4'd6: base_val = 64'd17;
      4'd7: base_val = 64'd19;
      4'd8: base_val = 64'd23;
      4'd9: base_val = 64'd29;
      4'd10: base_val = 64'd31;
      default: base_val = 64'd37;
    endcase
  endfunction

  // number of bases for a candidate
  function automatic bidx_t base_count(input word_t n);
    if (n < 64'd2046) base_count = 4'd1;
    else if (n < 64'd1373652) base_count = 4'd2;
    else if (n < 64'd25326000) base_count = 4'd3;
    else if (n < 64'd3215031750) base_count = 4'd4;
    else if (n < 64'd2152302898746) base_count = 4'd5;
    else if (n < 64'd3474749660382) base_count = 4'd6;
    else if (n < 64'd341550071728320) base_count = 4'd7;
    else if (n < 64'd3825123056546413050) base_count = 4'd9;
    else base_count = 4'd12;
  endfunction
endpackage
`default_nettype wire

>>> hw/rtl/mrpt_mulmod.sv
// shift-and-add modular multiplier, one bit of the multiplier per cycle
// uses mrpt_pkg
`default_nettype none
module mrpt_mulmod (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic go,
  input  wire mrpt_pkg::word_t x,   // already below m
  input  wire mrpt_pkg::word_t y,
  input  wire mrpt_pkg::word_t m,
  output logic busy,
  output mrpt_pkg::word_t prod
);
  mrpt_pkg::word_t acc, xr, yr, dbl, add;
  logic [5:0] bit_cnt;

  // (a + b) mod m with a, b < m
  function automatic mrpt_pkg::word_t add_mod(input mrpt_pkg::word_t a,
      input mrpt_pkg::word_t b, input mrpt_pkg::word_t mm);
    mrpt_pkg::word_t gap;
    gap = mm - b;
    add_mod = (a >= gap) ? a - gap : a + b;
  endfunction

  assign dbl = add_mod(acc, acc, m);
  assign add = yr[63] ? add_mod(dbl, xr, m) : dbl;
  assign prod = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      bit_cnt <= '0;
    end else if (go) begin
      busy <= 1'b1;
      bit_cnt <= '0;
      acc <= '0;
      xr <= x;
      yr <= y;
    end else if (busy) begin
      acc <= add;
      yr <= {yr[62:0], 1'b0};
      bit_cnt <= bit_cnt + 6'd1;
      if (bit_cnt == 6'd63) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

>>> hw/rtl/mrpt_datapath.sv
// datapath: candidate, exponent, witness registers and the multiplier
// uses mrpt_pkg and mrpt_mulmod
`default_nettype none
module mrpt_datapath (
  input  wire logic clk,
  input  wire logic rst,
  input  wire mrpt_pkg::word_t candidate,
  input  wire mrpt_pkg::cmd_t cmd,
  input  wire mrpt_pkg::bidx_t base_idx,
  output mrpt_pkg::stat_t stat
);
  mrpt_pkg::word_t n, d, e, g, acc, mx, my, prod, nm1, bv;
  logic [5:0] r, j;
  mrpt_pkg::bidx_t k;
  logic busy;

  assign nm1 = n - 64'd1;
  assign bv = mrpt_pkg::base_val(base_idx);

  always_comb begin
    case (cmd.mul_sel)
      mrpt_pkg::MulAccG: begin mx = g; my = acc; end
      mrpt_pkg::MulGG: begin mx = g; my = g; end
      default: begin mx = acc; my = acc; end
    endcase
  end

  mrpt_mulmod u_mul (
    .clk(clk), .rst(rst), .go(cmd.mul_go), .x(mx), .y(my), .m(n),
    .busy(busy), .prod(prod)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n <= candidate;
      d <= candidate - 64'd1;
      r <= '0;
      k <= mrpt_pkg::base_count(candidate);
    end
    if (cmd.strip) begin
      d <= {1'b0, d[63:1]};
      r <= r + 6'd1;
    end
    if (cmd.bstart) begin
      acc <= 64'd1;
      g <= (bv < n) ? bv : '0;   // base not below n never arises
      e <= d;
      j <= 6'd1;
    end
    if (cmd.mul_done_acc) begin
      case (cmd.mul_sel)
        mrpt_pkg::MulGG: begin
          g <= prod;
          e <= {1'b0, e[63:1]};
        end
        default: acc <= prod;
      endcase
    end
    if (cmd.sq_inc) j <= j + 6'd1;
  end

  always_comb begin
    stat.small_lt2 = n < 64'd2;
    stat.is_two = n == 64'd2;
    stat.is_even = ~n[0];
    stat.d_odd = d[0];
    stat.e_zero = e == '0;
    stat.e_lsb = e[0];
    stat.mul_busy = busy;
    stat.x_pass = (acc == 64'd1) || (acc == nm1);
    stat.x_nm1 = acc == nm1;
    stat.sq_last = j >= r;
    stat.base_last = (base_idx + 4'd1) == k;
  end
endmodule
`default_nettype wire

>>> hw/rtl/mrpt_ctrl.sv
// controller state machine for the prime test
// uses mrpt_pkg
`default_nettype none
module mrpt_ctrl (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  wire logic out_stall,
  output logic result,
  output mrpt_pkg::cmd_t cmd,
  output mrpt_pkg::bidx_t base_idx,
  input  wire mrpt_pkg::stat_t stat
);
  mrpt_pkg::state_t state, state_next;
  mrpt_pkg::bidx_t base_idx_next;
  logic ov_next, res_next;
  logic verdict, verdict_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mrpt_pkg::S_IDLE;
      out_valid <= 1'b0;
      base_idx <= '0;
    end else begin
      state <= state_next;
      out_valid <= ov_next;
      base_idx <= base_idx_next;
    end
  end

  always_ff @(posedge clk) begin
    result <= res_next;
    verdict <= verdict_next;
  end

  always_comb begin
    state_next = state;
    base_idx_next = base_idx;
    cmd = '0;
    cmd.mul_sel = mrpt_pkg::MulAccG;
    ov_next = out_valid && out_stall;
    res_next = result;
    verdict_next = verdict;
    in_stall = 1'b1;
    case (state)
      mrpt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = mrpt_pkg::S_CHECK;
        end
      end
      mrpt_pkg::S_CHECK: begin
        base_idx_next = '0;
        if (stat.small_lt2 || stat.is_two || stat.is_even) begin
          verdict_next = stat.is_two;
          state_next = mrpt_pkg::S_DONE;
        end else state_next = mrpt_pkg::S_STRIP;
      end
      mrpt_pkg::S_STRIP: begin
        if (stat.d_odd) state_next = mrpt_pkg::S_BSTART;
        else cmd.strip = 1'b1;
      end
      mrpt_pkg::S_BSTART: begin
        cmd.bstart = 1'b1;
        state_next = mrpt_pkg::S_PSTEP;
      end
      mrpt_pkg::S_PSTEP: begin
        if (stat.e_zero) state_next = mrpt_pkg::S_EVAL;
        else if (stat.e_lsb) begin
          cmd.mul_go = 1'b1;
          cmd.mul_sel = mrpt_pkg::MulAccG;
          state_next = mrpt_pkg::S_PMUL;
        end else begin
          cmd.mul_go = 1'b1;
          cmd.mul_sel = mrpt_pkg::MulGG;
          state_next = mrpt_pkg::S_PSQ;
        end
      end
      mrpt_pkg::S_PMUL: begin
        cmd.mul_sel = mrpt_pkg::MulAccG;
        if (!stat.mul_busy) begin
          cmd.mul_done_acc = 1'b1;
          state_next = mrpt_pkg::S_PSQGO;
        end
      end
      mrpt_pkg::S_PSQGO: begin
        // square g once the product has landed in acc
        cmd.mul_go = 1'b1;
        cmd.mul_sel = mrpt_pkg::MulGG;
        state_next = mrpt_pkg::S_PSQ;
      end
      mrpt_pkg::S_PSQ: begin
        cmd.mul_sel = mrpt_pkg::MulGG;
        if (!stat.mul_busy) begin
          cmd.mul_done_acc = 1'b1;
          state_next = mrpt_pkg::S_PSTEP;
        end
      end
      mrpt_pkg::S_EVAL: begin
        if (stat.x_pass) begin
          if (stat.base_last) begin
            verdict_next = 1'b1;
            state_next = mrpt_pkg::S_DONE;
          end else begin
            base_idx_next = base_idx + 4'd1;
            state_next = mrpt_pkg::S_BSTART;
          end
        end else if (stat.sq_last) begin
          verdict_next = 1'b0;
          state_next = mrpt_pkg::S_DONE;
        end else begin
          cmd.mul_go = 1'b1;
          cmd.mul_sel = mrpt_pkg::MulXX;
          state_next = mrpt_pkg::S_SQ;
        end
      end
      mrpt_pkg::S_SQ: begin
        cmd.mul_sel = mrpt_pkg::MulXX;
        if (!stat.mul_busy) begin
          cmd.mul_done_acc = 1'b1;
          cmd.sq_inc = 1'b1;
          state_next = mrpt_pkg::S_SQCHK;
        end
      end
      mrpt_pkg::S_SQCHK: begin
        // after a squaring only n-1 passes
        if (stat.x_nm1) begin
          if (stat.base_last) begin
            verdict_next = 1'b1;
            state_next = mrpt_pkg::S_DONE;
          end else begin
            base_idx_next = base_idx + 4'd1;
            state_next = mrpt_pkg::S_BSTART;
          end
        end else if (stat.sq_last) begin
          verdict_next = 1'b0;
          state_next = mrpt_pkg::S_DONE;
        end else begin
          cmd.mul_go = 1'b1;
          cmd.mul_sel = mrpt_pkg::MulXX;
          state_next = mrpt_pkg::S_SQ;
        end
      end
      mrpt_pkg::S_DONE: begin
        if (!(out_valid && out_stall)) begin
          ov_next = 1'b1;
          res_next = verdict;
          state_next = mrpt_pkg::S_IDLE;
        end
      end
      default: state_next = mrpt_pkg::S_IDLE;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != mrpt_pkg::S_IDLE |-> in_stall)
    else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("stalled result changed");
  a_base_range: assert property (@(posedge clk) disable iff (rst)
    base_idx < 4'(mrpt_pkg::NumBases))
    else $error("base index out of range");
`endif
endmodule
`default_nettype wire

>>> hw/rtl/miller_rabin_prime_test_64_unit.sv
// top level of the 64-bit deterministic miller-rabin prime test
// uses mrpt_pkg, mrpt_ctrl, mrpt_datapath
`default_nettype none
// one unsigned 64-bit candidate in, one prime_flag out. below 2, 2 and even
// values are settled by the first checks. an odd candidate is tested against 1 to 12
// prime bases chosen by its size. each modular multiply is one bit per cycle
// in a single shared shift-add unit: it is started, stays busy while the
// bits are worked, and then the product is taken. a bit of the exponent
// costs at most a product and a squaring of g, and d has at most 63 bits;
// each witness squaring is one more multiply, and exponent bits plus
// witness squarings never exceed 63. small or composite candidates finish
// far sooner, with fewer bases or an early exit. one item is worked at a
// time; the finished result sits in an output register so the next
// candidate can be taken while it waits for its transfer.
module miller_rabin_prime_test_64_unit (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic in_stall,
  input  wire logic [63:0] candidate,
  output logic out_valid,
  input  wire logic out_stall,
  output logic prime_flag
);
  mrpt_pkg::cmd_t cmd;
  mrpt_pkg::stat_t stat;
  mrpt_pkg::bidx_t base_idx;

  // sequencing of checks, exponentiation and witness squarings
  mrpt_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .result(prime_flag),
    .cmd(cmd), .base_idx(base_idx), .stat(stat)
  );

  // registers and the modular multiplier
  mrpt_datapath u_dp (
    .clk(clk), .rst(rst), .candidate(candidate), .cmd(cmd),
    .base_idx(base_idx), .stat(stat)
  );
endmodule
`default_nettype wire

>>> tb/prime_flag_checker.sv
// checker for the 64-bit miller-rabin prime test unit: predicts and compares prime_flag
// depends on mrpt_pkg for the word type; watches both channels of the block
`timescale 1ns / 1ps
module prime_flag_checker (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  input  wire logic in_stall,
  input  wire logic [63:0] candidate,
  input  wire logic out_valid,
  input  wire logic out_stall,
  input  wire logic prime_flag,
  output int fail_count,
  output int pending
);
  bit expected_flags[$];

  // (a * b) mod m with a double-width product
  function automatic mrpt_pkg::word_t prod_mod(input mrpt_pkg::word_t a,
      input mrpt_pkg::word_t b, input mrpt_pkg::word_t m);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    return mrpt_pkg::word_t'(prod % {64'd0, m});
  endfunction

  function automatic mrpt_pkg::word_t mod_power(input mrpt_pkg::word_t g,
      input mrpt_pkg::word_t e, input mrpt_pkg::word_t m);
    mrpt_pkg::word_t acc;
    mrpt_pkg::word_t sq;
    mrpt_pkg::word_t ex;
    acc = 64'd1;
    sq = g % m;
    ex = e;
    if (sq == 64'd0) return 64'd0;
    while (ex != 64'd0) begin
      if (ex[0]) acc = prod_mod(acc, sq, m);
      ex = ex >> 1;
      sq = prod_mod(sq, sq, m);
    end
    return acc;
  endfunction

  function automatic bit is_prime_64(input mrpt_pkg::word_t n);
    mrpt_pkg::word_t odd_part;
    mrpt_pkg::word_t x;
    mrpt_pkg::word_t witnesses[12];
    int unsigned twos;
    int unsigned nbases;
    bit ok;
    witnesses = '{64'd2, 64'd3, 64'd5, 64'd7, 64'd11, 64'd13, 64'd17, 64'd19,
                  64'd23, 64'd29, 64'd31, 64'd37};
    if (n < 64'd2) return 1'b0;
    if (n == 64'd2) return 1'b1;
    if (!n[0]) return 1'b0;
    if (n < 64'd2046) nbases = 1;
    else if (n < 64'd1373652) nbases = 2;
    else if (n < 64'd25326000) nbases = 3;
    else if (n < 64'd3215031750) nbases = 4;
    else if (n < 64'd2152302898746) nbases = 5;
    else if (n < 64'd3474749660382) nbases = 6;
    else if (n < 64'd341550071728320) nbases = 7;
    else if (n < 64'd3825123056546413050) nbases = 9;
    else nbases = 12;
    odd_part = n - 64'd1;
    twos = 0;
    while (!odd_part[0]) begin
      odd_part = odd_part >> 1;
      twos++;
    end
    for (int i = 0; i < nbases; i++) begin
      x = mod_power(witnesses[i], odd_part, n);
      ok = (x == 64'd1) || (x == n - 64'd1);
      for (int j = 1; !ok && j < twos; j++) begin
        x = prod_mod(x, x, n);
        if (x == n - 64'd1) ok = 1'b1;
      end
      if (!ok) return 1'b0;
    end
    return 1'b1;
  endfunction

  assign pending = expected_flags.size();

  initial fail_count = 0;

  always @(posedge clk) begin
    bit want;
    if (!rst) begin
      if (in_valid && !in_stall) expected_flags.push_back(is_prime_64(candidate));
      if (out_valid && !out_stall) begin
        if (expected_flags.size() == 0) begin
          $display("%0t: unexpected result transfer, prime_flag %0b", $time, prime_flag);
          fail_count++;
        end else begin
          want = expected_flags.pop_front();
          if (prime_flag !== want) begin
            $display("%0t: prime_flag mismatch, expected %0b actual %0b",
                     $time, want, prime_flag);
            fail_count++;
          end
        end
      end
    end
  end
endmodule

>>> tb/tb.sv
// top of the testbench for miller_rabin_prime_test_64_unit: clock, reset, stimulus, verdict
// depends on mrpt_pkg, the block and prime_flag_checker
`timescale 1ns / 1ps
module tb;
  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [63:0] candidate = 64'd0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic prime_flag;
  int fail_count;
  int pending;

  // idle chances in percent for the sender and the receiver
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  miller_rabin_prime_test_64_unit dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .candidate(candidate), .out_valid(out_valid), .out_stall(out_stall),
    .prime_flag(prime_flag)
  );

  prime_flag_checker u_checker (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .candidate(candidate), .out_valid(out_valid), .out_stall(out_stall),
    .prime_flag(prime_flag), .fail_count(fail_count), .pending(pending)
  );

  // receiver stalls at random, changed only at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // one candidate transfer; valid is only lowered when a gap is taken,
  // so back-to-back transfers never lower and raise valid in one step
  task automatic send_candidate(input mrpt_pkg::word_t value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    candidate <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // hold off the sender until every result has been transferred
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // mostly small candidates keep the run short; a few reach the top ranges
  function automatic mrpt_pkg::word_t random_candidate();
    int unsigned pick;
    mrpt_pkg::word_t v;
    pick = $urandom_range(99);
    v = {$urandom, $urandom};
    if (pick < 70) v = v & 64'hFFFF;
    else if (pick < 85) v = v & 64'hFFFF_FFFF;
    else if (pick < 93) v = v & 64'hFFFF_FFFF_FFFF;
    // bias toward odd values so the witness loop is exercised
    if ($urandom_range(99) < 80) v[0] = 1'b1;
    return v;
  endfunction

  initial begin
    mrpt_pkg::word_t directed[$];
    directed = '{
      64'd0, 64'd1, 64'd2, 64'd3, 64'd4, 64'd5, 64'd9,
      64'd2045, 64'd2047,              // edge of the one-base range
      64'd1373653, 64'd25326001,
      64'd3215031751,                  // strong pseudoprime to bases 2..7
      64'd2152302898747, 64'd3474749660383, 64'd341550071728321,
      64'd3825123056546413051,         // first odd value of the twelve-base range
      64'd2305843009213693951,         // 2^61-1, prime
      64'hFFFF_FFFF_FFFF_FFC5,         // largest 64-bit prime
      64'hFFFF_FFFF_FFFF_FFFE,         // largest even value
      64'hFFFF_FFFF_FFFF_FFFF,         // all ones, past the range table
      64'h8000_0000_0000_0000,
      64'h8000_0000_0000_0001
    };
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part with light idling
    send_idle_pct = 10;
    recv_idle_pct = 49;
    foreach (directed[i]) send_candidate(directed[i]);
    drain_results();

    // random part in three idling phases
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 49 : 0;
      recv_idle_pct = (phase == 0) ? 49 : (phase == 1) ? 10 : 0;
      repeat (26) send_candidate(random_candidate());
    end

    // wait for the last results, then a little settling time
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // watchdog for a hung handshake
  initial begin
    #1_000_000_000;
    $display("tb NOT OK");
    $finish;
  end
endmodule
